[rtl/slf_pkg.sv]
package slf_pkg;

  // width of the exact sums of products, signed
  localparam int unsigned W = 68;

  typedef struct packed {
    logic force_one;  // zero delta or zero denominator
    logic sat;        // quotient reaches 2.0 or more
    logic neg;        // quotient sign
    logic mode;       // limiter mode carried with the item
  } ctl_t;

endpackage

[rtl/slope_limiter_factor_top.sv]
// Slope limiter factor. Each item gives phi in signed Q2.FRAC_BITS, clamped to
// [-2, 2]: Venkatakrishnan form when limiter_mode is 0, Barth-Jespersen when 1,
// exactly 1.0 when face_delta or the denominator is zero. Fully pipelined: one
// item per cycle while the output is not stalled (four stages for the delta, the
// 33x33 products, the sums and the magnitudes, then one restoring-divider stage
// per quotient bit, then the output register). Stalls back up stage by stage, so
// empty stages still fill while the output is held. Write limiter_mode only
// when the pipeline is empty.
module slope_limiter_factor_top import slf_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [31:0]        cell_value_i,
  input  logic signed [31:0]        neighbor_min_i,
  input  logic signed [31:0]        neighbor_max_i,
  input  logic signed [31:0]        face_delta_i,
  input  logic [31:0]               epsilon_sq_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [FRAC_BITS+2:0] limit_factor_o
);

  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned NS = FRAC_BITS + 6;
  localparam int unsigned OW = FRAC_BITS + 3;

  logic mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // per-stage valid and enable
  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = !out_stall_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[NS-1];

  logic [W-1:0]  rem_s [QW+1];
  logic [W-1:0]  div_s [QW+1];
  logic [QW-1:0] quo_s [QW+1];
  ctl_t          ctl_s [QW+1];

  slf_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i          (clk_i),
    .en_i           (en[3:0]),
    .mode_i         (mode_q),
    .cell_value_i   (cell_value_i),
    .neighbor_min_i (neighbor_min_i),
    .neighbor_max_i (neighbor_max_i),
    .face_delta_i   (face_delta_i),
    .epsilon_sq_i   (epsilon_sq_i),
    .rem_o          (rem_s[0]),
    .div_o          (div_s[0]),
    .ctl_o          (ctl_s[0])
  );

  assign quo_s[0] = '0;

  for (genvar g = 0; g < QW; g++) begin : g_div
    slf_div_stage #(.QW(QW), .FIRST_STEP(g == 0)) u_step (
      .clk_i (clk_i),
      .en_i  (en[4+g]),
      .rem_i (rem_s[g]),
      .div_i (div_s[g]),
      .quo_i (quo_s[g]),
      .ctl_i (ctl_s[g]),
      .rem_o (rem_s[g+1]),
      .div_o (div_s[g+1]),
      .quo_o (quo_s[g+1]),
      .ctl_o (ctl_s[g+1])
    );
  end

  // output stage: clamp, sign, minimum with one in barth-jespersen mode
  localparam logic signed [OW-1:0] ONE   = OW'(1) <<< FRAC_BITS;
  localparam logic signed [OW-1:0] LIMIT = OW'(2) <<< FRAC_BITS;

  logic signed [OW-1:0] mag, phi_d;
  ctl_t                 c;

  always_comb begin
    c   = ctl_s[QW];
    mag = c.sat ? LIMIT : $signed(OW'(quo_s[QW]));
    if (c.force_one) begin
      phi_d = ONE;
    end else begin
      phi_d = c.neg ? -mag : mag;
      if (c.mode && (phi_d > ONE)) begin
        phi_d = ONE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      limit_factor_o <= phi_d;
    end
  end

endmodule

[rtl/slf_front.sv]
module slf_front import slf_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic [3:0]          en_i,
  input  logic                mode_i,
  input  logic signed [31:0]  cell_value_i,
  input  logic signed [31:0]  neighbor_min_i,
  input  logic signed [31:0]  neighbor_max_i,
  input  logic signed [31:0]  face_delta_i,
  input  logic [31:0]         epsilon_sq_i,
  output logic [W-1:0]        rem_o,
  output logic [W-1:0]        div_o,
  output ctl_t                ctl_o
);

  // stage a: d1 select
  logic signed [32:0] d1_q, d1_d, d2a_q;
  logic [31:0]        eea_q;
  logic               modea_q, zeroa_q;

  always_comb begin
    if (!face_delta_i[31]) begin
      d1_d = 33'(neighbor_max_i) - 33'(cell_value_i);
    end else begin
      d1_d = 33'(neighbor_min_i) - 33'(cell_value_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      d1_q    <= d1_d;
      d2a_q   <= 33'(face_delta_i);
      eea_q   <= epsilon_sq_i;
      modea_q <= mode_i;
      zeroa_q <= (face_delta_i == 32'sd0);
    end
  end

  // stage b: products
  logic signed [65:0] d1sq_q, d1d2_q, d2sq_q;
  logic signed [32:0] d1b_q, d2b_q;
  logic [31:0]        eeb_q;
  logic               modeb_q, zerob_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      d1sq_q  <= d1_q * d1_q;
      d1d2_q  <= d1_q * d2a_q;
      d2sq_q  <= d2a_q * d2a_q;
      d1b_q   <= d1_q;
      d2b_q   <= d2a_q;
      eeb_q   <= eea_q;
      modeb_q <= modea_q;
      zerob_q <= zeroa_q;
    end
  end

  // stage c: numerator and denominator
  logic signed [W-1:0] ees, num_d, den_d, num_q, den_q;
  logic                modec_q, zeroc_q;

  always_comb begin
    ees = $signed({{(W-32){1'b0}}, eeb_q} << FRAC_BITS);
    if (modeb_q) begin
      num_d = W'(d1b_q);
      den_d = W'(d2b_q);
    end else begin
      num_d = W'(d1sq_q) + ees + (W'(d1d2_q) <<< 1);
      den_d = W'(d1sq_q) + (W'(d2sq_q) <<< 1) + W'(d1d2_q) + ees;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      num_q   <= num_d;
      den_q   <= den_d;
      modec_q <= modeb_q;
      zeroc_q <= zerob_q;
    end
  end

  // stage d: magnitudes, sign and overflow check
  logic [W-1:0] an, ad;
  logic [W:0]   ad2;

  always_comb begin
    an  = num_q[W-1] ? W'(-num_q) : W'(num_q);
    ad  = den_q[W-1] ? W'(-den_q) : W'(den_q);
    ad2 = {ad, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      rem_o           <= an;
      div_o           <= ad;
      ctl_o.force_one <= zeroc_q || (ad == '0);
      ctl_o.sat       <= ({1'b0, an} >= ad2);
      ctl_o.neg       <= num_q[W-1] ^ den_q[W-1];
      ctl_o.mode      <= modec_q;
    end
  end

endmodule

[rtl/slf_div_stage.sv]
module slf_div_stage import slf_pkg::*; #(
  parameter int unsigned QW = 17,
  parameter bit FIRST_STEP = 1'b0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [W-1:0]  rem_i,
  input  logic [W-1:0]  div_i,
  input  logic [QW-1:0] quo_i,
  input  ctl_t          ctl_i,
  output logic [W-1:0]  rem_o,
  output logic [W-1:0]  div_o,
  output logic [QW-1:0] quo_o,
  output ctl_t          ctl_o
);

  logic [W-1:0] rs;
  logic         ge;

  always_comb begin
    // first step works on the unshifted remainder, which is below twice the divisor unless the item saturates
    rs = FIRST_STEP ? rem_i : {rem_i[W-2:0], 1'b0};
    ge = (rs >= div_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= ge ? rs - div_i : rs;
      div_o <= div_i;
      quo_o <= {quo_i[QW-2:0], ge};
      ctl_o <= ctl_i;
    end
  end

endmodule
